// ===== hdl/bol_pkg.sv =====
// ----------------------------------------------------------------------------
// bol_pkg
// Shared types and constants for the bounded ordered list: port widths,
// request codes and the per-cell load select.
// ----------------------------------------------------------------------------
package bol_pkg;

    // fixed widths of the request and result fields
    localparam int REQ_W   = 3;
    localparam int POS_W   = 6;
    localparam int KIND_W  = 4;
    localparam int VALUE_W = 16;
    localparam int LEN_W   = 7;

    // request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND = 3'd0,
        REQ_INSERT = 3'd1,
        REQ_REMOVE = 3'd2,
        REQ_PEEK   = 3'd3,
        REQ_CLEAR  = 3'd4
    } t_req;

    // what a cell loads at the next edge
    typedef enum logic [2:0] {
        SEL_HOLD,
        SEL_NEW,
        SEL_PREV,
        SEL_NEXT,
        SEL_ZERO
    } t_cell_sel;

endpackage

// ===== hdl/bol_cell.sv =====
// ----------------------------------------------------------------------------
// bol_cell
// One slot of the list: holds a kind and a value, loads new data, its
// neighbor toward the head or its neighbor toward the tail, or clears.
// ----------------------------------------------------------------------------
module bol_cell #(
    parameter int KIND_BITS  = 4,
    parameter int VALUE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  bol_pkg::t_cell_sel     i_sel,
    input  logic [KIND_BITS-1:0]   i_new_kind,
    input  logic [VALUE_BITS-1:0]  i_new_value,
    input  logic [KIND_BITS-1:0]   i_prev_kind,
    input  logic [VALUE_BITS-1:0]  i_prev_value,
    input  logic [KIND_BITS-1:0]   i_next_kind,
    input  logic [VALUE_BITS-1:0]  i_next_value,
    input  logic                   i_peek_hit,
    output logic [KIND_BITS-1:0]   o_kind,
    output logic [VALUE_BITS-1:0]  o_value,
    output logic [KIND_BITS-1:0]   o_peek_kind,
    output logic [VALUE_BITS-1:0]  o_peek_value
);

    logic [KIND_BITS-1:0]  r_kind;
    logic [VALUE_BITS-1:0] r_value;
    logic [KIND_BITS-1:0]  n_kind;
    logic [VALUE_BITS-1:0] n_value;

    // source select for the slot
    always_comb begin
        case (i_sel)
            bol_pkg::SEL_HOLD: begin
                n_kind  = r_kind;
                n_value = r_value;
            end
            bol_pkg::SEL_NEW: begin
                n_kind  = i_new_kind;
                n_value = i_new_value;
            end
            bol_pkg::SEL_PREV: begin
                n_kind  = i_prev_kind;
                n_value = i_prev_value;
            end
            bol_pkg::SEL_NEXT: begin
                n_kind  = i_next_kind;
                n_value = i_next_value;
            end
            default: begin
                n_kind  = '0;
                n_value = '0;
            end
        endcase
    end

    // slot storage, empty after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind  <= '0;
            r_value <= '0;
        end else begin
            r_kind  <= n_kind;
            r_value <= n_value;
        end
    end

    assign o_kind       = r_kind;
    assign o_value      = r_value;
    // gated read-out for the peek or-tree
    assign o_peek_kind  = i_peek_hit ? r_kind  : '0;
    assign o_peek_value = i_peek_hit ? r_value : '0;

endmodule

// ===== hdl/bounded_ordered_list_top.sv =====
// ----------------------------------------------------------------------------
// bounded_ordered_list_top
// Ordered list of up to CAPACITY kind/value entries held in a chain of cells;
// append, insert, remove, peek and clear, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in channel (i_in_valid / o_in_ready) with the
//   request code, position and the entry to append or insert. Each request
//   gives exactly one result on the out channel (o_out_valid / i_out_ready):
//   ok flag, peeked kind and value, and the list length after the request.
//   The result is registered: a request transferred at one edge shows its
//   result in the following cycle. One request is taken per cycle while the
//   receiver keeps up; all cells load at the same edge, shifts included.
//   The result sits in one output register; a new request is taken in the
//   same cycle the pending result is transferred, so a stalled receiver
//   holds off the in channel only while the result register is full.
//   Reset (synchronous, active low) empties the list, zeroes every cell and
//   drops any pending result; the block is ready right after reset.
//   Peek reads through an and-or tree over all cells into the result
//   register; kind and value ports are truncated or extended to the
//   stored widths KIND_BITS and VALUE_BITS.
// ----------------------------------------------------------------------------
module bounded_ordered_list_top #(
    parameter int CAPACITY   = 64,
    parameter int KIND_BITS  = 4,
    parameter int VALUE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bol_pkg::REQ_W-1:0]     i_req_type,
    input  logic [bol_pkg::POS_W-1:0]     i_position,
    input  logic [bol_pkg::KIND_W-1:0]    i_item_kind,
    input  logic [bol_pkg::VALUE_W-1:0]   i_item_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_ok,
    output logic [bol_pkg::KIND_W-1:0]    o_out_kind,
    output logic [bol_pkg::VALUE_W-1:0]   o_out_value,
    output logic [bol_pkg::LEN_W-1:0]     o_list_length
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > bol_pkg::POS_W) ? CNT_W : bol_pkg::POS_W;

    logic                   w_accept;
    bol_pkg::t_req          w_req;
    logic [CMP_W-1:0]       w_pos;
    logic [CMP_W-1:0]       w_cnt;
    logic                   w_full;
    logic                   w_app_ok;
    logic                   w_ins_ok;
    logic                   w_in_range;
    logic [KIND_BITS-1:0]   w_new_kind;
    logic [VALUE_BITS-1:0]  w_new_value;

    logic [KIND_BITS-1:0]   w_kind       [CAPACITY];
    logic [VALUE_BITS-1:0]  w_value      [CAPACITY];
    logic [KIND_BITS-1:0]   w_peek_kind  [CAPACITY];
    logic [VALUE_BITS-1:0]  w_peek_value [CAPACITY];
    bol_pkg::t_cell_sel     w_sel        [CAPACITY];

    logic [KIND_BITS-1:0]   w_rd_kind;
    logic [VALUE_BITS-1:0]  w_rd_value;
    logic                   n_ok;
    logic [CNT_W-1:0]       n_count;

    logic [CNT_W-1:0]             r_count;
    logic                         r_out_valid;
    logic                         r_ok;
    logic [bol_pkg::KIND_W-1:0]   r_out_kind;
    logic [bol_pkg::VALUE_W-1:0]  r_out_value;

    // handshake: take a request whenever the result register frees up
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // request decode and range checks
    assign w_req       = bol_pkg::t_req'(i_req_type);
    assign w_pos       = CMP_W'(i_position);
    assign w_cnt       = CMP_W'(r_count);
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_app_ok    = !w_full;
    assign w_ins_ok    = (w_pos <= w_cnt) && (w_pos < CMP_W'(CAPACITY));
    assign w_in_range  = (w_pos < w_cnt);
    assign w_new_kind  = KIND_BITS'(i_item_kind);
    assign w_new_value = VALUE_BITS'(i_item_value);

    // chain of cells with per-cell load select
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [CMP_W-1:0]      w_idx;
        logic [KIND_BITS-1:0]  w_pk;
        logic [VALUE_BITS-1:0] w_pv;
        logic [KIND_BITS-1:0]  w_nk;
        logic [VALUE_BITS-1:0] w_nv;

        assign w_idx = CMP_W'(g);

        if (g == 0) begin : g_head
            assign w_pk = '0;
            assign w_pv = '0;
        end else begin : g_body
            assign w_pk = w_kind[g-1];
            assign w_pv = w_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_nk = '0;
            assign w_nv = '0;
        end else begin : g_inner
            assign w_nk = w_kind[g+1];
            assign w_nv = w_value[g+1];
        end

        // what this cell loads for the current request
        always_comb begin
            w_sel[g] = bol_pkg::SEL_HOLD;
            if (w_accept) begin
                case (w_req)
                    bol_pkg::REQ_APPEND: begin
                        if (w_app_ok && (w_idx == w_cnt)) begin
                            w_sel[g] = bol_pkg::SEL_NEW;
                        end
                    end
                    bol_pkg::REQ_INSERT: begin
                        if (w_ins_ok) begin
                            if (w_idx == w_pos) begin
                                w_sel[g] = bol_pkg::SEL_NEW;
                            end else if (w_idx > w_pos) begin
                                w_sel[g] = bol_pkg::SEL_PREV;
                            end
                        end
                    end
                    bol_pkg::REQ_REMOVE: begin
                        if (w_in_range && (w_idx >= w_pos)) begin
                            w_sel[g] = bol_pkg::SEL_NEXT;
                        end
                    end
                    bol_pkg::REQ_CLEAR: begin
                        w_sel[g] = bol_pkg::SEL_ZERO;
                    end
                    default: begin
                        w_sel[g] = bol_pkg::SEL_HOLD;
                    end
                endcase
            end
        end

        bol_cell #(
            .KIND_BITS  (KIND_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_sel        (w_sel[g]),
            .i_new_kind   (w_new_kind),
            .i_new_value  (w_new_value),
            .i_prev_kind  (w_pk),
            .i_prev_value (w_pv),
            .i_next_kind  (w_nk),
            .i_next_value (w_nv),
            .i_peek_hit   (w_idx == w_pos),
            .o_kind       (w_kind[g]),
            .o_value      (w_value[g]),
            .o_peek_kind  (w_peek_kind[g]),
            .o_peek_value (w_peek_value[g])
        );
    end

    // peek read-out: or of the gated cell outputs
    always_comb begin
        w_rd_kind  = '0;
        w_rd_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_kind  = w_rd_kind  | w_peek_kind[k];
            w_rd_value = w_rd_value | w_peek_value[k];
        end
    end

    // result flag and next length
    always_comb begin
        n_ok    = 1'b0;
        n_count = r_count;
        case (w_req)
            bol_pkg::REQ_APPEND: begin
                n_ok = w_app_ok;
                if (w_app_ok) begin
                    n_count = r_count + 1'b1;
                end
            end
            bol_pkg::REQ_INSERT: begin
                n_ok = w_ins_ok;
                if (w_ins_ok && !w_full) begin
                    n_count = r_count + 1'b1;
                end
            end
            bol_pkg::REQ_REMOVE: begin
                n_ok = w_in_range;
                if (w_in_range) begin
                    n_count = r_count - 1'b1;
                end
            end
            bol_pkg::REQ_PEEK: begin
                n_ok = w_in_range;
            end
            bol_pkg::REQ_CLEAR: begin
                n_ok    = 1'b1;
                n_count = '0;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // length counter and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ok <= n_ok;
            if ((w_req == bol_pkg::REQ_PEEK) && w_in_range) begin
                r_out_kind  <= bol_pkg::KIND_W'(w_rd_kind);
                r_out_value <= bol_pkg::VALUE_W'(w_rd_value);
            end else begin
                r_out_kind  <= '0;
                r_out_value <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_out_kind    = r_out_kind;
    assign o_out_value   = r_out_value;
    assign o_list_length = bol_pkg::LEN_W'(r_count);

endmodule

// ===== tb/tb_bounded_ordered_list_top.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_ordered_list_top
// Self-checking bench for the bounded ordered list. A behavioral copy of the
// list predicts ok, peeked entry and length for every accepted request.
// Directed corner cases and a full-list pass are followed by random traffic
// under changing valid/ready idling, long output stalls and a second full-list pass.
// ----------------------------------------------------------------------------
module tb_bounded_ordered_list_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP    = 64;
    localparam int KIND_BITS   = 4;
    localparam int VALUE_BITS  = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 200;
    localparam int RANDOM_REQS = 235;

    // request codes the block treats as no-ops
    localparam logic [bol_pkg::REQ_W-1:0] REQ_SPARE_FIRST = bol_pkg::REQ_CLEAR + 3'd1;
    localparam logic [bol_pkg::REQ_W-1:0] REQ_SPARE_LAST  = '1;

    typedef struct packed {
        logic                        ok;
        logic [bol_pkg::KIND_W-1:0]  kind;
        logic [bol_pkg::VALUE_W-1:0] value;
        logic [bol_pkg::LEN_W-1:0]   len;
    } t_list_result;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          i_in_valid    = 1'b0;
    logic                          o_in_ready;
    logic [bol_pkg::REQ_W-1:0]     i_req_type    = '0;
    logic [bol_pkg::POS_W-1:0]     i_position    = '0;
    logic [bol_pkg::KIND_W-1:0]    i_item_kind   = '0;
    logic [bol_pkg::VALUE_W-1:0]   i_item_value  = '0;
    logic                          o_out_valid;
    logic                          i_out_ready   = 1'b0;
    logic                          o_ok;
    logic [bol_pkg::KIND_W-1:0]    o_out_kind;
    logic [bol_pkg::VALUE_W-1:0]   o_out_value;
    logic [bol_pkg::LEN_W-1:0]     o_list_length;

    // shadow copy of the list
    logic [bol_pkg::KIND_W-1:0]    lst_kind  [LIST_CAP];
    logic [bol_pkg::VALUE_W-1:0]   lst_value [LIST_CAP];
    int unsigned                   lst_len = 0;

    t_list_result         expected_results [$];
    int unsigned          error_count  = 0;
    int unsigned          cycle_count  = 0;
    int unsigned          snd_idle_pct = 0;
    int unsigned          rcv_idle_pct = 0;
    logic                 rx_hold      = 1'b0;
    event                 hold_rx;

    bounded_ordered_list_top #(
        .CAPACITY   (LIST_CAP),
        .KIND_BITS  (KIND_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_position    (i_position),
        .i_item_kind   (i_item_kind),
        .i_item_value  (i_item_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_ok          (o_ok),
        .o_out_kind    (o_out_kind),
        .o_out_value   (o_out_value),
        .o_list_length (o_list_length)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    endtask

    // apply one request to the shadow list and queue its result
    task automatic list_model_apply(input logic [bol_pkg::REQ_W-1:0] req,
                                    input logic [bol_pkg::POS_W-1:0] pos,
                                    input logic [bol_pkg::KIND_W-1:0] kind,
                                    input logic [bol_pkg::VALUE_W-1:0] value);
        t_list_result r;
        int unsigned  p;
        int unsigned  new_len;
        int unsigned  i;
        r = '0;
        p = pos;
        case (req)
            bol_pkg::REQ_APPEND: begin
                if (lst_len < LIST_CAP) begin
                    lst_kind[lst_len]  = kind;
                    lst_value[lst_len] = value;
                    lst_len++;
                    r.ok = 1'b1;
                end
            end
            bol_pkg::REQ_INSERT: begin
                if (p <= lst_len && p < LIST_CAP) begin
                    new_len = (lst_len < LIST_CAP) ? lst_len + 1 : LIST_CAP;
                    // shift toward the tail, a full list drops its last entry
                    for (i = new_len - 1; i > p; i--) begin
                        lst_kind[i]  = lst_kind[i-1];
                        lst_value[i] = lst_value[i-1];
                    end
                    lst_kind[p]  = kind;
                    lst_value[p] = value;
                    lst_len      = new_len;
                    r.ok         = 1'b1;
                end
            end
            bol_pkg::REQ_REMOVE: begin
                if (p < lst_len) begin
                    for (i = p; i + 1 < lst_len; i++) begin
                        lst_kind[i]  = lst_kind[i+1];
                        lst_value[i] = lst_value[i+1];
                    end
                    lst_kind[lst_len-1]  = '0;
                    lst_value[lst_len-1] = '0;
                    lst_len--;
                    r.ok = 1'b1;
                end
            end
            bol_pkg::REQ_PEEK: begin
                if (p < lst_len) begin
                    r.kind  = lst_kind[p];
                    r.value = lst_value[p];
                    r.ok    = 1'b1;
                end
            end
            bol_pkg::REQ_CLEAR: begin
                for (i = 0; i < LIST_CAP; i++) begin
                    lst_kind[i]  = '0;
                    lst_value[i] = '0;
                end
                lst_len = 0;
                r.ok    = 1'b1;
            end
            default: ;
        endcase
        r.len = bol_pkg::LEN_W'(lst_len);
        expected_results.push_back(r);
    endtask

    // one request transfer on the in channel, called at a rising edge
    task automatic send_req(input logic [bol_pkg::REQ_W-1:0] req,
                            input logic [bol_pkg::POS_W-1:0] pos,
                            input logic [bol_pkg::KIND_W-1:0] kind,
                            input logic [bol_pkg::VALUE_W-1:0] value);
        int unsigned gap;
        if ($urandom_range(0, 99) < snd_idle_pct) begin
            gap = $urandom_range(1, 3);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= req;
        i_position   <= pos;
        i_item_kind  <= kind;
        i_item_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        list_model_apply(req, pos, kind, value);
    endtask

    task automatic send_entry(input logic [bol_pkg::REQ_W-1:0] req,
                              input logic [bol_pkg::POS_W-1:0] pos);
        send_req(req, pos, bol_pkg::KIND_W'($urandom_range(0, 15)),
                 bol_pkg::VALUE_W'($urandom));
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_drained;
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_idling(input int unsigned snd, input int unsigned rcv);
        snd_idle_pct = snd;
        rcv_idle_pct = rcv;
    endtask

    // result checking and receiver readiness
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected, length",
                                32'(o_list_length), 0);
            end else begin
                want = expected_results.pop_front();
                if (o_ok !== want.ok) report_mismatch("ok", 32'(o_ok), 32'(want.ok));
                if (o_out_kind !== want.kind)
                    report_mismatch("kind", 32'(o_out_kind), 32'(want.kind));
                if (o_out_value !== want.value)
                    report_mismatch("value", 32'(o_out_value), 32'(want.value));
                if (o_list_length !== want.len)
                    report_mismatch("length", 32'(o_list_length), 32'(want.len));
            end
        end
        i_out_ready <= !rx_hold && ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // long receiver hold-off, counted here
    always begin
        @(hold_rx);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // corner cases on a short list
    task automatic test_directed_cases;
        logic [bol_pkg::REQ_W-1:0] code;
        int unsigned               i;
        send_req(bol_pkg::REQ_PEEK,   6'd0, 4'd0, 16'h0000);   // peek empty list
        send_req(bol_pkg::REQ_REMOVE, 6'd0, 4'd0, 16'h0000);   // remove from empty list
        send_req(bol_pkg::REQ_INSERT, 6'd1, 4'd3, 16'h1234);   // insert past the length
        send_req(bol_pkg::REQ_APPEND, 6'd0, 4'hF, 16'hFFFF);
        send_req(bol_pkg::REQ_APPEND, 6'd0, 4'h0, 16'h0000);
        send_req(bol_pkg::REQ_INSERT, 6'd0, 4'h1, 16'h0001);   // insert at head
        send_req(bol_pkg::REQ_INSERT, 6'd3, 4'hA, 16'hAAAA);   // insert at the length
        send_req(bol_pkg::REQ_INSERT, 6'd2, 4'h5, 16'h5555);   // insert in the middle
        for (i = 0; i < 6; i++)
            send_req(bol_pkg::REQ_PEEK, bol_pkg::POS_W'(i), 4'h0, 16'h0000);
        send_req(bol_pkg::REQ_PEEK,   6'd63, 4'hF, 16'hFFFF);
        send_req(bol_pkg::REQ_REMOVE, 6'd63, 4'hF, 16'hFFFF);
        send_req(bol_pkg::REQ_REMOVE, 6'd2, 4'h0, 16'h0000);   // middle
        send_req(bol_pkg::REQ_REMOVE, 6'd3, 4'h0, 16'h0000);   // tail
        send_req(bol_pkg::REQ_REMOVE, 6'd0, 4'h0, 16'h0000);   // head
        // unused request codes
        for (code = REQ_SPARE_FIRST; code != REQ_SPARE_LAST; code++)
            send_req(code, 6'd63, 4'hF, 16'hFFFF);
        send_req(REQ_SPARE_LAST, 6'd63, 4'hF, 16'hFFFF);
        send_req(bol_pkg::REQ_CLEAR,  6'd0, 4'h0, 16'h0000);
        send_req(bol_pkg::REQ_PEEK,   6'd0, 4'h0, 16'h0000);
        send_req(bol_pkg::REQ_APPEND, 6'd0, 4'h8, 16'h8000);
    endtask

    // fill to capacity, exercise the full-list rules, then drain
    task automatic test_full_list;
        int unsigned i;
        send_req(bol_pkg::REQ_CLEAR, 6'd0, 4'h0, 16'h0000);
        for (i = 0; i < LIST_CAP; i++) send_entry(bol_pkg::REQ_APPEND, 6'd0);
        send_entry(bol_pkg::REQ_APPEND, 6'd0);                   // append to full list
        send_entry(bol_pkg::REQ_INSERT, 6'd0);                   // drops the last entry
        send_entry(bol_pkg::REQ_INSERT, 6'd63);                  // replaces the last entry
        send_entry(bol_pkg::REQ_INSERT, bol_pkg::POS_W'($urandom_range(1, 62)));
        send_req(bol_pkg::REQ_PEEK, 6'd63, 4'h0, 16'h0000);
        send_req(bol_pkg::REQ_REMOVE, 6'd63, 4'h0, 16'h0000);
        send_entry(bol_pkg::REQ_INSERT, 6'd63);                  // insert at the length
        send_req(bol_pkg::REQ_PEEK, 6'd63, 4'h0, 16'h0000);
        // drain from head, tail and the middle
        while (lst_len != 0) begin
            case ($urandom_range(0, 2))
                0:       send_req(bol_pkg::REQ_REMOVE, 6'd0, 4'h0, 16'h0000);
                1:       send_req(bol_pkg::REQ_REMOVE, bol_pkg::POS_W'(lst_len - 1),
                                  4'h0, 16'h0000);
                default: send_req(bol_pkg::REQ_REMOVE,
                                  bol_pkg::POS_W'($urandom_range(0, lst_len - 1)),
                                  4'h0, 16'h0000);
            endcase
        end
        send_req(bol_pkg::REQ_REMOVE, 6'd0, 4'h0, 16'h0000);
    endtask

    function automatic logic [bol_pkg::REQ_W-1:0] REQ_TYPE_SPARE();
        return bol_pkg::REQ_W'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
    endfunction

    // random traffic that drifts between growing and shrinking the list
    task automatic test_random_traffic(input int unsigned count);
        int unsigned               n;
        int unsigned               sel;
        int unsigned               add_pct;
        int unsigned               rem_pct;
        logic                      grow;
        logic [bol_pkg::REQ_W-1:0] req;
        logic [bol_pkg::POS_W-1:0] pos;
        grow = 1'b1;
        for (n = 0; n < count; n++) begin
            if (lst_len == LIST_CAP) grow = 1'b0;
            else if (lst_len == 0) grow = 1'b1;
            else if ($urandom_range(0, 99) < 3) grow = !grow;
            add_pct = grow ? 60 : 20;
            rem_pct = grow ? 10 : 40;
            sel     = $urandom_range(0, 99);
            if (sel < add_pct) begin
                req = $urandom_range(0, 1) ? bol_pkg::REQ_APPEND : bol_pkg::REQ_INSERT;
                pos = (req == bol_pkg::REQ_INSERT) ? bol_pkg::POS_W'($urandom_range(0, lst_len))
                                                   : bol_pkg::POS_W'($urandom);
            end else if (sel < add_pct + rem_pct) begin
                req = bol_pkg::REQ_REMOVE;
                pos = (lst_len != 0) ? bol_pkg::POS_W'($urandom_range(0, lst_len - 1)) : '0;
            end else if (sel < 92) begin
                req = bol_pkg::REQ_PEEK;
                pos = (lst_len != 0) ? bol_pkg::POS_W'($urandom_range(0, lst_len - 1)) : '0;
            end else if (sel < 93) begin
                req = bol_pkg::REQ_CLEAR;
                pos = bol_pkg::POS_W'($urandom);
            end else if (sel < 96) begin
                req = REQ_TYPE_SPARE();
                pos = bol_pkg::POS_W'($urandom);
            end else begin
                // noise: append, insert, remove or peek at any position
                req = bol_pkg::REQ_W'($urandom_range(bol_pkg::REQ_APPEND, bol_pkg::REQ_PEEK));
                pos = bol_pkg::POS_W'($urandom);
            end
            send_entry(req, pos);
        end
    endtask

    // hold the out channel so the block fills and stalls its input
    task automatic test_output_stall;
        int unsigned i;
        -> hold_rx;
        for (i = 0; i < 24; i++) begin
            if (lst_len < LIST_CAP / 2) send_entry(bol_pkg::REQ_APPEND, 6'd0);
            else send_req(bol_pkg::REQ_PEEK, bol_pkg::POS_W'($urandom_range(0, lst_len - 1)),
                          4'h0, 16'h0);
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < LIST_CAP; i++) begin
            lst_kind[i]  = '0;
            lst_value[i] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_idling(30, 70);
        test_directed_cases();
        test_full_list();
        test_random_traffic(RANDOM_REQS);
        wait_drained();
        test_output_stall();

        set_idling(70, 30);
        test_random_traffic(RANDOM_REQS);
        wait_drained();

        set_idling(0, 0);
        test_random_traffic(RANDOM_REQS);
        test_output_stall();
        test_full_list();
        wait_drained();

        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
